// ----- rtl/core/dtpwm_pkg.sv -----
// ----------------------------------------------------------------------------
// dtpwm_pkg
// Shared types, reset constants and the debounce step of the toggle dimmer.
// ----------------------------------------------------------------------------
package dtpwm_pkg;

  localparam int unsigned DATA_W       = 8;
  localparam int unsigned PIN_W        = 8;
  localparam int unsigned CHANNELS_DEF = 8;
  localparam int unsigned CFG_IDX_W    = 2;

  localparam logic [DATA_W-1:0] PERIOD_RST   = 8'd20;
  localparam logic [DATA_W-1:0] DEBOUNCE_RST = 8'd100;
  localparam logic [DATA_W-1:0] BRIGHT_RST   = 8'd21;
  localparam logic [DATA_W-1:0] DIM_RST      = 8'd2;
  localparam logic [DATA_W-1:0] COUNT_MAX    = 8'hff;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD   = 2'd0,
    REG_DEBOUNCE = 2'd1,
    REG_BRIGHT   = 2'd2,
    REG_DIM      = 2'd3
  } reg_idx_t;

  // per tick control shared by all channels
  typedef struct packed {
    logic              advance;
    logic              wrap;
    logic [DATA_W-1:0] phase;
    logic [DATA_W-1:0] debounce_ticks;
    logic [DATA_W-1:0] bright_duty;
    logic [DATA_W-1:0] dim_duty;
  } chan_ctrl_t;

  typedef struct packed {
    logic              last;
    logic [DATA_W-1:0] cnt;
    logic              acc;
  } deb_t;

  function automatic deb_t debounce_step(deb_t d, logic s, logic [DATA_W-1:0] limit);
    deb_t r;
    r = d;
    if (d.last == s) begin
      if (d.cnt != COUNT_MAX) begin
        r.cnt = d.cnt + 8'd1;
      end
      if (r.cnt > limit) begin
        r.acc = d.last;
      end
    end else begin
      r.cnt = '0;
    end
    r.last = s;
    return r;
  endfunction

endpackage

// ----- rtl/core/dtpwm_phase.sv -----
// ----------------------------------------------------------------------------
// dtpwm_phase
// Shared pwm phase counter: advances each tick, wraps at the period.
// ----------------------------------------------------------------------------
module dtpwm_phase (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          advance,
  input  logic [dtpwm_pkg::DATA_W-1:0]  period_ticks,
  output logic                          wrap,
  output logic [dtpwm_pkg::DATA_W-1:0]  phase_nxt
);

  logic [dtpwm_pkg::DATA_W-1:0] phase_r;
  logic [dtpwm_pkg::DATA_W:0]   inc;

  // a stale phase above a lowered period also wraps
  assign inc       = {1'b0, phase_r} + 9'd1;
  assign wrap      = inc >= {1'b0, period_ticks};
  assign phase_nxt = wrap ? '0 : inc[dtpwm_pkg::DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
    end
  end

endmodule

// ----- rtl/core/dtpwm_channel.sv -----
// ----------------------------------------------------------------------------
// dtpwm_channel
// One button/led channel: debounce, drive-low test and toggle on press.
// ----------------------------------------------------------------------------
module dtpwm_channel (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dtpwm_pkg::chan_ctrl_t ctrl,
  input  logic                  sample,
  output logic                  release_bit,
  output logic                  led_nxt
);

  dtpwm_pkg::deb_t              deb_r, deb_wrap, deb_nxt;
  logic                         seen_r, ind_r, bright_r;
  logic                         seen_nxt, bright_nxt;
  logic [dtpwm_pkg::DATA_W-1:0] duty;
  logic                         drive_low;
  logic                         fall;

  assign duty      = bright_r ? ctrl.bright_duty : ctrl.dim_duty;
  assign drive_low = ctrl.phase > duty;

  // wrap debounces once more before the normal pass
  always_comb begin
    deb_wrap = ctrl.wrap ? dtpwm_pkg::debounce_step(deb_r, sample, ctrl.debounce_ticks)
                         : deb_r;
    deb_nxt  = drive_low ? deb_wrap
                         : dtpwm_pkg::debounce_step(deb_wrap, sample, ctrl.debounce_ticks);
  end

  assign fall        = seen_r & ~deb_nxt.acc;
  assign seen_nxt    = deb_nxt.acc;
  assign led_nxt     = ind_r ^ fall;
  assign bright_nxt  = bright_r ^ fall;
  assign release_bit = ~drive_low;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r    <= '{last: 1'b1, cnt: '0, acc: 1'b1};
      seen_r   <= 1'b1;
      ind_r    <= 1'b0;
      bright_r <= 1'b1;
    end else if (ctrl.advance) begin
      deb_r    <= deb_nxt;
      seen_r   <= seen_nxt;
      ind_r    <= led_nxt;
      bright_r <= bright_nxt;
    end
  end

endmodule

// ----- rtl/core/debounced_toggle_pwm_dimmer.sv -----
// ----------------------------------------------------------------------------
// debounced_toggle_pwm_dimmer
// Debounced toggle buttons sharing their pins with a pwm led dimmer.
// ----------------------------------------------------------------------------
// usage:
//   in_*   one transfer per timer tick carrying the eight sampled pin levels
//   out_*  one transfer per tick: pin_release and led_state after the tick
//   cfg_*  register writes (period, debounce, bright duty, dim duty), always
//          ready, only to be issued while the block is idle
// path: a tick is registered on the input stage and its result is then
//   registered on the output register once that register is free or taken
// throughput: one tick per cycle unless stalled; per channel debounce and
//   toggle is a single combinational pass between input and output registers
// stall: while out_ready is low the result holds and the input stage keeps
//   one more tick, after which in_ready drops until the result is taken
// reset: phase zero, all buttons seen released, leds off, bright duty selected,
//   registers back to their defaults; both stages empty
// ----------------------------------------------------------------------------
module debounced_toggle_pwm_dimmer #(
  parameter int unsigned CHANNELS = dtpwm_pkg::CHANNELS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [dtpwm_pkg::PIN_W-1:0]      in_pin_levels,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [dtpwm_pkg::PIN_W-1:0]      out_pin_release,
  output logic [dtpwm_pkg::PIN_W-1:0]      out_led_state,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dtpwm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dtpwm_pkg::DATA_W-1:0]     cfg_data
);

  logic [dtpwm_pkg::DATA_W-1:0] period_r, debounce_r, bright_r, dim_r;
  logic                         s0_valid_r;
  logic [dtpwm_pkg::PIN_W-1:0]  s0_pins_r;
  logic                         out_valid_r;
  logic [dtpwm_pkg::PIN_W-1:0]  release_r, led_r;
  logic [dtpwm_pkg::PIN_W-1:0]  release_nxt, led_nxt;
  logic [CHANNELS-1:0]          ch_release, ch_led;
  logic                         advance;
  logic                         wrap;
  logic [dtpwm_pkg::DATA_W-1:0] phase_nxt;
  dtpwm_pkg::chan_ctrl_t        ctrl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r   <= dtpwm_pkg::PERIOD_RST;
      debounce_r <= dtpwm_pkg::DEBOUNCE_RST;
      bright_r   <= dtpwm_pkg::BRIGHT_RST;
      dim_r      <= dtpwm_pkg::DIM_RST;
    end else if (cfg_valid) begin
      unique case (dtpwm_pkg::reg_idx_t'(cfg_index))
        dtpwm_pkg::REG_PERIOD:   period_r   <= cfg_data;
        dtpwm_pkg::REG_DEBOUNCE: debounce_r <= cfg_data;
        dtpwm_pkg::REG_BRIGHT:   bright_r   <= cfg_data;
        dtpwm_pkg::REG_DIM:      dim_r      <= cfg_data;
        default:                 period_r   <= period_r;
      endcase
    end
  end

  // tick moves from input stage to output register
  assign advance   = s0_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s0_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_pin_release = release_r;
  assign out_led_state   = led_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s0_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_pins_r <= in_pin_levels;
    end
    if (advance) begin
      release_r <= release_nxt;
      led_r     <= led_nxt;
    end
  end

  dtpwm_phase u_phase (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (advance),
    .period_ticks (period_r),
    .wrap         (wrap),
    .phase_nxt    (phase_nxt)
  );

  assign ctrl = '{advance:        advance,
                  wrap:           wrap,
                  phase:          phase_nxt,
                  debounce_ticks: debounce_r,
                  bright_duty:    bright_r,
                  dim_duty:       dim_r};

  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_ch
    logic sample;
    // channels beyond the pin word always sample released
    if (ch < dtpwm_pkg::PIN_W) begin : g_pin
      assign sample = s0_pins_r[ch];
    end else begin : g_idle
      assign sample = 1'b1;
    end

    dtpwm_channel u_channel (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .sample      (sample),
      .release_bit (ch_release[ch]),
      .led_nxt     (ch_led[ch])
    );
  end

  for (genvar b = 0; b < dtpwm_pkg::PIN_W; b++) begin : g_out
    if (b < CHANNELS) begin : g_used
      assign release_nxt[b] = ch_release[b];
      assign led_nxt[b]     = ch_led[b];
    end else begin : g_unused
      assign release_nxt[b] = 1'b0;
      assign led_nxt[b]     = 1'b0;
    end
  end

endmodule

// ----- rtl/core/dtpwm_checker.sv -----
// ----------------------------------------------------------------------------
// dtpwm_checker
// Port level checks on the dimmer's handshakes, bound to the top level.
// ----------------------------------------------------------------------------
module dtpwm_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [dtpwm_pkg::PIN_W-1:0]     out_pin_release,
  input logic [dtpwm_pkg::PIN_W-1:0]     out_led_state
);

  // result register empty after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pin_release)
                                && $stable(out_led_state))
    else $error("stalled result changed");

  // input only blocks while a result waits on a stalled receiver
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // a tick taken with no result waiting reaches the output via both registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> ##1 out_valid)
    else $error("result missing after accepted tick");

endmodule

bind debounced_toggle_pwm_dimmer dtpwm_checker u_dtpwm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_pin_release (out_pin_release),
  .out_led_state   (out_led_state)
);

// ----- tb/debounced_toggle_pwm_dimmer_tb.sv -----
// ----------------------------------------------------------------------------
// debounced_toggle_pwm_dimmer_tb
// Drives timer ticks of sampled pin levels through the dimmer, with random
// gaps on both sides. A local model of the phase counter, the debouncers and
// the toggle logic predicts untyped results; each is compared field by field.
// ----------------------------------------------------------------------------
module debounced_toggle_pwm_dimmer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [dtpwm_pkg::PIN_W-1:0] pins_up;
    logic [dtpwm_pkg::PIN_W-1:0] leds;
  } tick_res_t;

  typedef struct packed {
    logic                        reprog;
    logic [dtpwm_pkg::PIN_W-1:0] pins;
    logic                        typed;
    logic [dtpwm_pkg::PIN_W-1:0] up;
    logic [dtpwm_pkg::PIN_W-1:0] leds;
  } dir_row_t;

  typedef struct packed {
    logic [dtpwm_pkg::DATA_W-1:0] per;
    logic [dtpwm_pkg::DATA_W-1:0] deb;
    logic [dtpwm_pkg::DATA_W-1:0] bri;
    logic [dtpwm_pkg::DATA_W-1:0] dim;
    logic [9:0]                   n;
  } phase_t;

  localparam int N_DIR = 20;
  // first six rows run on reset defaults: phase stays below the bright duty
  // and the debounce count is far off, so all pins stay up and leds stay off
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{1'b0, 8'hff, 1'b1, 8'hff, 8'h00},
    '{1'b0, 8'h00, 1'b1, 8'hff, 8'h00},
    '{1'b0, 8'haa, 1'b1, 8'hff, 8'h00},
    '{1'b0, 8'h55, 1'b1, 8'hff, 8'h00},
    '{1'b0, 8'h00, 1'b1, 8'hff, 8'h00},
    '{1'b0, 8'h00, 1'b1, 8'hff, 8'h00},
    // short period below the current phase, so the next tick wraps at once
    '{1'b1, 8'h00, 1'b0, 8'h00, 8'h00},
    '{1'b0, 8'h00, 1'b0, 8'h00, 8'h00},
    '{1'b0, 8'h00, 1'b0, 8'h00, 8'h00},
    '{1'b0, 8'hff, 1'b0, 8'h00, 8'h00},
    '{1'b0, 8'hff, 1'b0, 8'h00, 8'h00},
    '{1'b0, 8'hff, 1'b0, 8'h00, 8'h00},
    '{1'b0, 8'h00, 1'b0, 8'h00, 8'h00},
    '{1'b0, 8'h00, 1'b0, 8'h00, 8'h00},
    '{1'b0, 8'h00, 1'b0, 8'h00, 8'h00},
    '{1'b0, 8'h0f, 1'b0, 8'h00, 8'h00},
    '{1'b0, 8'hf0, 1'b0, 8'h00, 8'h00},
    '{1'b0, 8'h5a, 1'b0, 8'h00, 8'h00},
    '{1'b0, 8'ha5, 1'b0, 8'h00, 8'h00},
    '{1'b0, 8'hff, 1'b0, 8'h00, 8'h00}
  };

  localparam int N_FIXED = 6;
  localparam int N_PHASES = 8;
  // period, debounce, bright duty, dim duty, ticks
  localparam phase_t PHASES [N_FIXED] = '{
    '{8'd4,   8'd1,   8'd255, 8'd0,   10'd70},
    '{8'd1,   8'd2,   8'd0,   8'd255, 10'd60},
    '{8'd0,   8'd3,   8'd5,   8'd1,   10'd40},
    '{8'd255, 8'd1,   8'd128, 8'd60,  10'd80},
    '{8'd7,   8'd5,   8'd3,   8'd6,   10'd70},
    '{8'd1,   8'd254, 8'd255, 8'd0,   10'd220}
  };

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  logic [dtpwm_pkg::PIN_W-1:0]     in_pin_levels;
  logic                            out_valid;
  logic                            out_ready;
  logic [dtpwm_pkg::PIN_W-1:0]     out_pin_release;
  logic [dtpwm_pkg::PIN_W-1:0]     out_led_state;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [dtpwm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [dtpwm_pkg::DATA_W-1:0]    cfg_data;

  // expected result typed into the table, travels alongside the payload
  logic                            typed_on;
  logic [dtpwm_pkg::PIN_W-1:0]     typed_up;
  logic [dtpwm_pkg::PIN_W-1:0]     typed_led;

  // dimmer model state
  logic [dtpwm_pkg::DATA_W-1:0]    per_q, deb_q, bri_q, dim_q, ph_q;
  logic [dtpwm_pkg::PIN_W-1:0]     last_s, acc_lv, seen_lv, led_q, bright_q;
  logic [dtpwm_pkg::DATA_W-1:0]    steady [dtpwm_pkg::PIN_W];

  tick_res_t          pending_res [$];
  tick_res_t          mon_exp, mon_got;

  bit                 rx_free, tx_free, rx_hold_req;
  int unsigned        n_ticks, n_checked, n_toggles, n_low, errors;

  // random pin pattern generator
  logic [dtpwm_pkg::PIN_W-1:0]     held_pat, bounce_mask, pins;
  int unsigned        run_left, bounce_left;
  phase_t             ph;

  debounced_toggle_pwm_dimmer i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pin_levels   (in_pin_levels),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pin_release (out_pin_release),
    .out_led_state   (out_led_state),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("debounced_toggle_pwm_dimmer_tb: done, errors");
    $finish;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // one debounce step of a channel
  function automatic void sample_pin(input int ch, input logic s);
    if (last_s[ch] == s) begin
      if (steady[ch] != dtpwm_pkg::COUNT_MAX) begin
        steady[ch] = steady[ch] + 8'd1;
      end
      if (steady[ch] > deb_q) begin
        acc_lv[ch] = last_s[ch];
      end
    end else begin
      steady[ch] = '0;
    end
    last_s[ch] = s;
  endfunction

  function automatic tick_res_t dimmer_tick(input logic [dtpwm_pkg::PIN_W-1:0] lv);
    tick_res_t                    r;
    logic [dtpwm_pkg::DATA_W:0]   nxt;
    logic                         wrap;
    logic [dtpwm_pkg::DATA_W-1:0] duty;
    nxt  = {1'b0, ph_q} + 1'b1;
    wrap = nxt >= {1'b0, per_q};
    ph_q = wrap ? '0 : nxt[dtpwm_pkg::DATA_W-1:0];
    r.pins_up = '0;
    for (int ch = 0; ch < dtpwm_pkg::PIN_W; ch++) begin
      duty = bright_q[ch] ? bri_q : dim_q;
      // a wrap debounces every channel once more with the same sample
      if (wrap) sample_pin(ch, lv[ch]);
      if (!(ph_q > duty)) begin
        r.pins_up[ch] = 1'b1;
        sample_pin(ch, lv[ch]);
      end
    end
    for (int ch = 0; ch < dtpwm_pkg::PIN_W; ch++) begin
      if (seen_lv[ch] != acc_lv[ch]) begin
        if (seen_lv[ch] && !acc_lv[ch]) begin
          led_q[ch]    = ~led_q[ch];
          bright_q[ch] = ~bright_q[ch];
          n_toggles++;
        end
        seen_lv[ch] = acc_lv[ch];
      end
    end
    r.leds = led_q;
    if (r.pins_up != '1) n_low++;
    return r;
  endfunction

  // transfers on both channels, seen at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      mon_exp = dimmer_tick(in_pin_levels);
      if (typed_on) mon_exp = '{pins_up: typed_up, leds: typed_led};
      pending_res.push_back(mon_exp);
      n_ticks++;
    end
    if (rst_n && out_valid && out_ready) begin
      mon_got = '{pins_up: out_pin_release, leds: out_led_state};
      if (pending_res.size() == 0) begin
        $error("result %02h/%02h with no tick outstanding", mon_got.pins_up, mon_got.leds);
        errors++;
      end else begin
        mon_exp = pending_res.pop_front();
        n_checked++;
        if (mon_got.pins_up !== mon_exp.pins_up) begin
          $error("pin_release: expected %02h, got %02h", mon_exp.pins_up, mon_got.pins_up);
          errors++;
        end
        if (mon_got.leds !== mon_exp.leds) begin
          $error("led_state: expected %02h, got %02h", mon_exp.leds, mon_got.leds);
          errors++;
        end
      end
    end
  end

  // result side back-pressure
  initial begin
    out_ready = 1'b0;
    forever begin
      if (rx_hold_req) begin
        out_ready <= 1'b0;
        repeat (64) @(negedge clk);
        rx_hold_req = 1'b0;
      end else if (rx_free) begin
        out_ready <= 1'b1;
        @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        out_ready <= 1'b0;
        repeat (idle_len() + 1) @(negedge clk);
      end
    end
  end

  task automatic send_tick(input logic [dtpwm_pkg::PIN_W-1:0] lv, input logic typed,
                           input logic [dtpwm_pkg::PIN_W-1:0] up,
                           input logic [dtpwm_pkg::PIN_W-1:0] leds);
    int unsigned gap;
    in_valid      <= 1'b1;
    in_pin_levels <= lv;
    typed_on      <= typed;
    typed_up      <= up;
    typed_led     <= leds;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    gap = tx_free ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // stop offering and wait for every outstanding result
  task automatic flush_ticks();
    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input dtpwm_pkg::reg_idx_t idx,
                           input logic [dtpwm_pkg::DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      dtpwm_pkg::REG_PERIOD:   per_q = val;
      dtpwm_pkg::REG_DEBOUNCE: deb_q = val;
      dtpwm_pkg::REG_BRIGHT:   bri_q = val;
      dtpwm_pkg::REG_DIM:      dim_q = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [dtpwm_pkg::DATA_W-1:0] per,
                              input logic [dtpwm_pkg::DATA_W-1:0] deb,
                              input logic [dtpwm_pkg::DATA_W-1:0] bri,
                              input logic [dtpwm_pkg::DATA_W-1:0] dim);
    write_reg(dtpwm_pkg::REG_PERIOD, per);
    write_reg(dtpwm_pkg::REG_DEBOUNCE, deb);
    write_reg(dtpwm_pkg::REG_BRIGHT, bri);
    write_reg(dtpwm_pkg::REG_DIM, dim);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_pin_levels = '1;
    typed_on      = 1'b0;
    typed_up      = '0;
    typed_led     = '0;
    cfg_valid     = 1'b0;
    cfg_index     = dtpwm_pkg::REG_PERIOD;
    cfg_data      = '0;
    rx_free       = 1'b0;
    tx_free       = 1'b0;
    rx_hold_req   = 1'b0;
    per_q    = dtpwm_pkg::PERIOD_RST;
    deb_q    = dtpwm_pkg::DEBOUNCE_RST;
    bri_q    = dtpwm_pkg::BRIGHT_RST;
    dim_q    = dtpwm_pkg::DIM_RST;
    ph_q     = '0;
    last_s   = '1;
    acc_lv   = '1;
    seen_lv  = '1;
    led_q    = '0;
    bright_q = '1;
    for (int ch = 0; ch < dtpwm_pkg::PIN_W; ch++) steady[ch] = '0;
    held_pat    = '1;
    bounce_mask = '0;
    run_left    = 0;
    bounce_left = 0;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      if (DIR_ROWS[i].reprog) begin
        flush_ticks();
        program_regs(8'd3, 8'd1, 8'd255, 8'd0);
      end
      send_tick(DIR_ROWS[i].pins, DIR_ROWS[i].typed, DIR_ROWS[i].up, DIR_ROWS[i].leds);
    end

    for (int i = 0; i < N_PHASES; i++) begin
      if (i < N_FIXED) begin
        ph = PHASES[i];
      end else begin
        ph = '{per: 8'($urandom_range(1, 40)), deb: 8'($urandom_range(1, 12)),
               bri: 8'($urandom_range(0, 255)), dim: 8'($urandom_range(0, 255)),
               n: 10'd45};
      end
      flush_ticks();
      program_regs(ph.per, ph.deb, ph.bri, ph.dim);
      // one phase runs flat out on both sides
      tx_free = (i == 1);
      rx_free = (i == 1);
      run_left = 0;
      for (int k = 0; k < ph.n; k++) begin
        // long receiver hold-off while ticks keep coming, fills the pipe
        if (i == 0 && k == 30) rx_hold_req = 1'b1;
        if (i == 3 && k == 40) flush_ticks();
        if ($urandom_range(0, 99) < 15) begin
          pins = 8'($urandom_range(0, 255));
        end else begin
          if (run_left == 0) begin
            bounce_mask = $urandom_range(0, 1) ? (8'h01 << $urandom_range(0, 7))
                                               : 8'($urandom_range(1, 255));
            held_pat    = held_pat ^ bounce_mask;
            bounce_left = $urandom_range(0, 3);
            run_left    = $urandom_range(0, 1) ? $urandom_range(1, 6)
                                               : $urandom_range(int'(deb_q) / 2 + 1,
                                                                int'(deb_q) + 6);
          end
          run_left--;
          pins = held_pat;
          // contact bounce on the bits that just changed
          if (bounce_left != 0) begin
            bounce_left--;
            pins = held_pat ^ (bounce_mask & 8'($urandom_range(0, 255)));
          end
        end
        send_tick(pins, 1'b0, '0, '0);
      end
    end

    flush_ticks();
    repeat (8) @(posedge clk);
    if (pending_res.size() != 0) begin
      $error("%0d results never arrived", pending_res.size());
      errors++;
    end
    $display("covered %0d ticks over %0d register settings, periods 0 to 255, debounce 1 to 254",
             n_ticks, N_PHASES + 2);
    $display("%0d results compared, %0d led toggles, %0d ticks with a pin pulled low",
             n_checked, n_toggles, n_low);
    if (errors == 0) begin
      $display("debounced_toggle_pwm_dimmer_tb: done, clean");
    end else begin
      $display("debounced_toggle_pwm_dimmer_tb: done, errors");
    end
    $finish;
  end

endmodule
